[rtl/core/lwbc_pkg.sv]
// Shared types and codes for the LRU write-back cache controller.
package lwbc_pkg;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic OP_FETCH     = 1'b0;
    localparam logic OP_WRITEBACK = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_EMIT_WB,
        S_EMIT_FETCH
    } t_state;

endpackage

[rtl/core/lru_write_back_cache_controller.sv]
// Top level of the LRU write-back cache controller.
//  channel  | direction | handshake          | words
//  request  | in        | push / full        | i_cmd, i_block_addr
//  memory   | out       | empty / pop        | o_mem_op, o_mem_block, o_last
// A hit reads the set, then looks up and updates it; a miss then emits one
// memory word per state (a write-back if the victim is dirty, then the fetch),
// each held until popped. All per-way set RAMs share one single address port.
// Reset clears the per-set fill flags, so fill counts read as zero; line contents stay unknown until written.
// A two-word request queue keeps accepting while results wait.
module lru_write_back_cache_controller #(
    parameter int WAYS       = 4,
    parameter int SETS       = 64,
    parameter int ADDR_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_cmd,
    input  logic [31:0] i_block_addr,
    output logic        empty,
    input  logic        pop,
    output logic        o_mem_op,
    output logic [31:0] o_mem_block,
    output logic        o_last
);
    logic                  w_valid, w_take, w_cmd;
    logic [ADDR_WIDTH-1:0] w_addr;

    lwbc_front #(.ADDR_WIDTH(ADDR_WIDTH)) u_front (
        .i_clk, .i_rst_n,
        .i_push(push), .i_cmd, .i_block_addr, .o_full(full),
        .o_req_valid(w_valid), .o_req_cmd(w_cmd), .o_req_addr(w_addr),
        .i_req_take(w_take)
    );

    lwbc_back #(.WAYS(WAYS), .SETS(SETS), .ADDR_WIDTH(ADDR_WIDTH)) u_back (
        .i_clk, .i_rst_n,
        .i_req_valid(w_valid), .i_req_cmd(w_cmd), .i_req_addr(w_addr),
        .o_req_take(w_take), .o_empty(empty), .i_pop(pop),
        .o_mem_op, .o_mem_block, .o_last
    );
endmodule

[rtl/core/lwbc_ram.sv]
// Generic single-port RAM with registered read data.
module lwbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[rtl/core/lwbc_front.sv]
// Front end: two-entry request queue that decouples accepted words from the cache engine.
module lwbc_front #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_cmd,
    input  logic [31:0]           i_block_addr,
    output logic                  o_full,
    output logic                  o_req_valid,
    output logic                  o_req_cmd,
    output logic [ADDR_WIDTH-1:0] o_req_addr,
    input  logic                  i_req_take
);
    logic [ADDR_WIDTH:0] r_q [2];
    logic                r_wp, r_rp;
    logic [1:0]          r_cnt;
    logic                w_push, w_pop;

    assign o_full      = (r_cnt == 2'd2);
    assign w_push      = i_push && !o_full;
    assign o_req_valid = (r_cnt != 2'd0);
    assign w_pop       = i_req_take && o_req_valid;
    assign o_req_cmd   = r_q[r_rp][ADDR_WIDTH];
    assign o_req_addr  = r_q[r_rp][ADDR_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            // Address bits above ADDR_WIDTH are dropped here.
            r_q[r_wp] <= {i_cmd, i_block_addr[ADDR_WIDTH-1:0]};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

[rtl/core/lwbc_back.sv]
// Back end: set lookup, LRU update, victim choice and memory word output.
module lwbc_back #(
    parameter int WAYS       = 4,
    parameter int SETS       = 64,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_cmd,
    input  logic [ADDR_WIDTH-1:0] i_req_addr,
    output logic                  o_req_take,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic                  o_mem_op,
    output logic [31:0]           o_mem_block,
    output logic                  o_last
);
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int FW = $clog2(WAYS + 1);

    lwbc_pkg::t_state r_state, n_state;

    logic                  r_cmd;
    logic [ADDR_WIDTH-1:0] r_addr;
    logic [SW-1:0]         r_set;
    logic [ADDR_WIDTH-1:0] r_victim;
    // One flag per set tells whether its fill count RAM entry has been written.
    logic                  r_fill_vld [SETS];

    logic [ADDR_WIDTH-1:0] w_blk_rd [WAYS];
    logic                  w_dty_rd [WAYS];
    logic [WW-1:0]         w_rank_rd [WAYS];
    logic [WW-1:0]         w_rank_wd [WAYS];
    logic                  w_blk_we [WAYS];
    logic                  w_dty_we [WAYS];
    logic                  w_dty_wd [WAYS];
    logic                  w_rank_we;
    logic [FW-1:0]         w_fill_rd;
    logic [FW-1:0]         w_fill_wd;
    logic                  w_fill_we;
    logic [SW-1:0]         w_ram_set;
    logic [SW-1:0]         w_req_set;

    logic [FW-1:0] w_filled;
    logic          w_hit;
    logic [WW-1:0] w_hit_way;
    logic [WW-1:0] w_lru_way;
    logic [WW-1:0] w_way;
    logic [WW-1:0] w_old_rank;
    logic          w_allocate;
    logic          w_wb;

    // Set index: (addr / WAYS) mod SETS; both are powers of two in use.
    always_comb begin
        logic [ADDR_WIDTH+1:0] q;
        q = {2'b00, i_req_addr} / WAYS;
        w_req_set = SW'(q % SETS);
    end

    assign o_req_take = (r_state == lwbc_pkg::S_IDLE);
    assign w_ram_set  = (r_state == lwbc_pkg::S_IDLE) ? w_req_set : r_set;
    assign w_filled   = r_fill_vld[r_set] ? w_fill_rd : '0;

    always_comb begin
        w_hit      = 1'b0;
        w_hit_way  = '0;
        w_lru_way  = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (FW'(i) < w_filled && w_blk_rd[i] == r_addr && !w_hit) begin
                w_hit     = 1'b1;
                w_hit_way = WW'(i);
            end
            if (w_rank_rd[i] == WW'(WAYS - 1)) begin
                w_lru_way = WW'(i);
            end
        end
        w_allocate = (w_filled < FW'(WAYS));
        w_way      = w_hit ? w_hit_way : (w_allocate ? WW'(w_filled) : w_lru_way);
        w_old_rank = w_rank_rd[w_way];
        w_wb       = !w_hit && !w_allocate && w_dty_rd[w_lru_way];
    end

    // New or touched line becomes most recent; younger lines age.
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            if (WW'(i) == w_way) begin
                w_rank_wd[i] = '0;
            end else if (FW'(i) < w_filled &&
                         (w_allocate && !w_hit || w_rank_rd[i] < w_old_rank)) begin
                w_rank_wd[i] = w_rank_rd[i] + 1'b1;
            end else begin
                w_rank_wd[i] = w_rank_rd[i];
            end
        end
    end

    assign w_rank_we = (r_state == lwbc_pkg::S_LOOKUP);
    assign w_fill_we = (r_state == lwbc_pkg::S_LOOKUP) && !w_hit && w_allocate;
    assign w_fill_wd = w_filled + 1'b1;

    lwbc_ram #(.WIDTH(FW), .DEPTH(SETS)) u_fill (
        .i_clk  (i_clk),
        .i_we   (w_fill_we),
        .i_addr (w_ram_set),
        .i_wdata(w_fill_wd),
        .o_rdata(w_fill_rd)
    );

    for (genvar g = 0; g < WAYS; g++) begin : g_way
        lwbc_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(SETS)) u_blk (
            .i_clk  (i_clk),
            .i_we   (w_blk_we[g]),
            .i_addr (w_ram_set),
            .i_wdata(r_addr),
            .o_rdata(w_blk_rd[g])
        );
        lwbc_ram #(.WIDTH(1), .DEPTH(SETS)) u_dty (
            .i_clk  (i_clk),
            .i_we   (w_dty_we[g]),
            .i_addr (w_ram_set),
            .i_wdata(w_dty_wd[g]),
            .o_rdata(w_dty_rd[g])
        );
        lwbc_ram #(.WIDTH(WW), .DEPTH(SETS)) u_rank (
            .i_clk  (i_clk),
            .i_we   (w_rank_we),
            .i_addr (w_ram_set),
            .i_wdata(w_rank_wd[g]),
            .o_rdata(w_rank_rd[g])
        );
        always_comb begin
            logic sel;
            sel = (r_state == lwbc_pkg::S_LOOKUP) && (w_way == WW'(g));
            w_blk_we[g] = sel && !w_hit;
            w_dty_we[g] = sel && (!w_hit || r_cmd == lwbc_pkg::CMD_WRITE);
            w_dty_wd[g] = r_cmd;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lwbc_pkg::S_IDLE: begin
                if (i_req_valid) n_state = lwbc_pkg::S_LOOKUP;
            end
            lwbc_pkg::S_LOOKUP: begin
                if (w_hit)     n_state = lwbc_pkg::S_IDLE;
                else if (w_wb) n_state = lwbc_pkg::S_EMIT_WB;
                else           n_state = lwbc_pkg::S_EMIT_FETCH;
            end
            lwbc_pkg::S_EMIT_WB: begin
                if (i_pop) n_state = lwbc_pkg::S_EMIT_FETCH;
            end
            lwbc_pkg::S_EMIT_FETCH: begin
                if (i_pop) n_state = lwbc_pkg::S_IDLE;
            end
            default: n_state = lwbc_pkg::S_IDLE;
        endcase
    end

    assign o_empty     = !(r_state == lwbc_pkg::S_EMIT_WB ||
                           r_state == lwbc_pkg::S_EMIT_FETCH);
    assign o_mem_op    = (r_state == lwbc_pkg::S_EMIT_WB) ? lwbc_pkg::OP_WRITEBACK
                                                          : lwbc_pkg::OP_FETCH;
    assign o_mem_block = 32'((r_state == lwbc_pkg::S_EMIT_WB) ? r_victim : r_addr);
    assign o_last      = (r_state == lwbc_pkg::S_EMIT_FETCH);

    always_ff @(posedge i_clk) begin
        if (r_state == lwbc_pkg::S_IDLE && i_req_valid) begin
            r_cmd  <= i_req_cmd;
            r_addr <= i_req_addr;
            r_set  <= w_req_set;
        end
        if (r_state == lwbc_pkg::S_LOOKUP) begin
            r_victim <= w_blk_rd[w_lru_way];
        end
        if (!i_rst_n) begin
            r_state <= lwbc_pkg::S_IDLE;
            for (int s = 0; s < SETS; s++) r_fill_vld[s] <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fill_we) r_fill_vld[r_set] <= 1'b1;
        end
    end
endmodule

[rtl/core/lwbc_checker.sv]
// Port-level checker for the cache controller, bound to the top level.
module lwbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic        o_mem_op,
    input logic [31:0] o_mem_block,
    input logic        o_last
);
    // A write-back word is never the final word of an access.
    a_wb_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_mem_op) |-> !o_last) else $error("write-back marked last");

    // A fetch word always closes its access.
    a_fetch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_mem_op) |-> o_last) else $error("fetch not last");

    // A popped write-back is followed at once by its fetch.
    a_wb_then_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_mem_op) |=> (!empty && !o_mem_op))
        else $error("write-back not followed by fetch");

    // A stalled word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_mem_block) && $stable(o_mem_op)))
        else $error("result changed while stalled");
endmodule

bind lru_write_back_cache_controller lwbc_checker u_lwbc_checker (
    .i_clk, .i_rst_n, .empty, .pop, .o_mem_op, .o_mem_block, .o_last
);
